/* rtl/fba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fba_pkg;

  typedef enum logic [2:0] {
    CMD_MARK    = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_TEST    = 3'd2,
    CMD_ALLOC   = 3'd3,
    CMD_RUN     = 3'd4,
    CMD_USAGE   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_WAIT,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_e;

  localparam int unsigned WordBits   = 32;
  localparam int unsigned FrameShift = 12;
  localparam int unsigned KibMax     = 262143;

endpackage
`default_nettype wire

/* rtl/frame_bitmap_allocator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Bitmap frame allocator. One used bit is kept for each 4 KiB frame, packed
// into 32-bit words in a single-port-read, single-port-write RAM. After reset
// the block runs a clearing pass over all MAX_FRAMES/32 words (1024 by
// default), during which no request is accepted. Mark and release step
// through read, wait, scan, write and done; test skips the write, and a frame
// beyond the store goes from read straight to done. Allocate, run search and
// usage walk the bitmap through a single word-wide scan unit. Each word takes
// a wait state and a scan state, because the RAM read is registered; a scan
// stops early at the first hit. The run search handles a whole word per scan
// step: for each bit the free length ending there comes from the highest used
// bit at or below it, or from the run carried in from earlier words. A
// finished result sits in an output register and stays unchanged while it is
// stalled; the next request is taken once it has been delivered.
module frame_bitmap_allocator_unit #(
  parameter int unsigned MAX_FRAMES = 32768
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [31:0] frame_address_i,
  input  wire logic [15:0] run_length_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [14:0]      frame_index_o,
  output logic             is_used_o,
  output logic [17:0]      used_kib_o,
  output logic [1:0]       status_o
);

  localparam int unsigned Words = MAX_FRAMES / fba_pkg::WordBits;
  localparam int unsigned AW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned CW    = $clog2(MAX_FRAMES + 1);
  localparam int unsigned FW    = $clog2(MAX_FRAMES);

  fba_pkg::state_e state_q, state_d;

  logic [15:0]  fcount_q;
  logic [2:0]   cmd_q;
  logic [19:0]  frame_q;
  logic [15:0]  want_q;
  logic [AW:0]  addr_q, addr_d;
  logic [CW-1:0] run_q, run_d;
  logic [CW-1:0] used_q, used_d;
  logic [14:0]  idx_q, idx_d;
  logic         isu_q, isu_d;
  logic [17:0]  kib_q, kib_d;
  logic [1:0]   st_q, st_d;
  logic         outv_q;
  logic [31:0]  wdata_q, wdata_d;

  logic         we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]  wdata, rdata;

  // Effective count saturated to the store size, and whole words below it.
  logic [CW-1:0] count;
  logic [CW-1:0] nwords;
  assign count  = ({4'd0, fcount_q} > 20'(MAX_FRAMES)) ? CW'(MAX_FRAMES)
                                                        : CW'(fcount_q);
  assign nwords = count >> 5;

  logic        in_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != fba_pkg::S_IDLE) || outv_q;

  logic        frame_in_store;
  assign frame_in_store = ({12'd0, frame_q} < 32'(MAX_FRAMES));

  fba_ram #(.Width(32), .Depth(Words)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Scan helpers on the word just read.
  logic [4:0]  ffz;
  logic        has_zero;
  logic [5:0]  pop;
  always_comb begin
    ffz = '0;
    has_zero = 1'b0;
    pop = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!rdata[i]) begin
        ffz = 5'(i);
        has_zero = 1'b1;
      end
    end
    for (int i = 0; i < 32; i++) begin
      pop = pop + 6'(rdata[i]);
    end
  end

  // Run search over one word. Frames at or past the count are treated as
  // used. While no used bit has been seen in the word, the run carried in
  // from earlier words continues and only the remainder still needed counts.
  logic         run_hit;
  logic [4:0]   run_bit;
  logic [CW-1:0] run_end;
  logic [CW+4:0] fbase;
  always_comb begin
    logic [31:0] u;
    logic [31:0] need;
    logic [5:0]  lastp;
    logic        hit_i;
    fbase = {addr_q[AW-1:0], 5'd0};
    need = ({16'd0, want_q} > 32'(run_q)) ? ({16'd0, want_q} - 32'(run_q)) : 32'd0;
    lastp = '0;
    hit_i = 1'b0;
    run_hit = 1'b0;
    run_bit = '0;
    for (int i = 0; i < 32; i++) begin
      u[i] = rdata[i] || ((fbase + (CW+5)'(i)) >= (CW+5)'(count));
      if (u[i]) lastp = 6'(i + 1);
      if (lastp == '0) hit_i = (32'(i + 1) >= need);
      else hit_i = ({26'd0, 6'(i + 1) - lastp} >= {16'd0, want_q});
      if (hit_i && !run_hit) begin
        run_hit = 1'b1;
        run_bit = 5'(i);
      end
    end
    run_end = (lastp == '0) ? (run_q + CW'(32)) : CW'(6'd32 - lastp);
  end

  logic [4:0] bitsel;
  assign bitsel = frame_q[4:0];
  logic [AW-1:0] fword;
  assign fword = AW'(frame_q >> 5);

  assign raddr = (state_q == fba_pkg::S_IDLE || state_q == fba_pkg::S_CLEAR)
                 ? AW'(0)
                 : ((cmd_q == fba_pkg::CMD_MARK || cmd_q == fba_pkg::CMD_RELEASE ||
                     cmd_q == fba_pkg::CMD_TEST) ? fword : addr_q[AW-1:0]);

  // Next state.
  always_comb begin
    logic last;
    state_d = state_q;
    last = ((AW+1)'(addr_q) + 1'b1) >= (AW+1)'(
      (cmd_q == fba_pkg::CMD_RUN) ? ((count + 31) >> 5) : nwords);
    case (state_q)
      fba_pkg::S_CLEAR: begin
        if (addr_q == (AW+1)'(Words - 1)) state_d = fba_pkg::S_IDLE;
      end
      fba_pkg::S_IDLE: begin
        if (in_acc) state_d = fba_pkg::S_READ;
      end
      fba_pkg::S_READ: begin
        case (cmd_q)
          fba_pkg::CMD_MARK, fba_pkg::CMD_RELEASE, fba_pkg::CMD_TEST:
            state_d = frame_in_store ? fba_pkg::S_WAIT : fba_pkg::S_DONE;
          fba_pkg::CMD_ALLOC, fba_pkg::CMD_USAGE:
            state_d = (nwords == '0) ? fba_pkg::S_DONE : fba_pkg::S_WAIT;
          fba_pkg::CMD_RUN:
            state_d = (want_q == '0 || count == '0) ? fba_pkg::S_DONE
                                                   : fba_pkg::S_WAIT;
          default: state_d = fba_pkg::S_DONE;
        endcase
      end
      fba_pkg::S_WAIT: state_d = fba_pkg::S_SCAN;
      fba_pkg::S_SCAN: begin
        case (cmd_q)
          fba_pkg::CMD_MARK: begin
            state_d = ({12'd0, frame_q} < 32'(count)) ? fba_pkg::S_WRITE
                                                      : fba_pkg::S_DONE;
          end
          fba_pkg::CMD_RELEASE: state_d = fba_pkg::S_WRITE;
          fba_pkg::CMD_TEST: state_d = fba_pkg::S_DONE;
          fba_pkg::CMD_ALLOC: begin
            if (has_zero) state_d = fba_pkg::S_WRITE;
            else if (last) state_d = fba_pkg::S_DONE;
            else state_d = fba_pkg::S_WAIT;
          end
          fba_pkg::CMD_RUN: begin
            if (run_hit || last) state_d = fba_pkg::S_DONE;
            else state_d = fba_pkg::S_WAIT;
          end
          fba_pkg::CMD_USAGE: begin
            state_d = last ? fba_pkg::S_DONE : fba_pkg::S_WAIT;
          end
          default: state_d = fba_pkg::S_DONE;
        endcase
      end
      fba_pkg::S_WRITE: state_d = fba_pkg::S_DONE;
      fba_pkg::S_DONE: state_d = fba_pkg::S_IDLE;
      default: state_d = fba_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    addr_d  = addr_q;
    run_d   = run_q;
    used_d  = used_q;
    idx_d   = idx_q;
    isu_d   = isu_q;
    kib_d   = kib_q;
    st_d    = st_q;
    wdata_d = wdata_q;
    we      = 1'b0;
    waddr   = addr_q[AW-1:0];
    wdata   = wdata_q;
    case (state_q)
      fba_pkg::S_CLEAR: begin
        we     = 1'b1;
        wdata  = '0;
        addr_d = addr_q + 1'b1;
      end
      fba_pkg::S_IDLE: begin
        // The previous result is held until a new request is taken.
        if (in_acc) begin
          addr_d = '0;
          run_d  = '0;
          used_d = '0;
          idx_d  = '0;
          isu_d  = 1'b0;
          kib_d  = '0;
          st_d   = fba_pkg::ST_OK;
        end
      end
      fba_pkg::S_READ: begin
        case (cmd_q)
          fba_pkg::CMD_MARK, fba_pkg::CMD_RELEASE, fba_pkg::CMD_TEST:
            if (!frame_in_store) st_d = fba_pkg::ST_RANGE;
          fba_pkg::CMD_ALLOC: st_d = fba_pkg::ST_FULL;
          fba_pkg::CMD_RUN:
            st_d = (want_q == '0 && count != '0) ? fba_pkg::ST_OK : fba_pkg::ST_FULL;
          default: ;
        endcase
      end
      fba_pkg::S_SCAN: begin
        addr_d = addr_q + 1'b1;
        case (cmd_q)
          fba_pkg::CMD_MARK: begin
            if ({12'd0, frame_q} < 32'(count)) begin
              wdata_d = rdata | (32'd1 << bitsel);
            end else begin
              st_d = fba_pkg::ST_RANGE;
            end
          end
          fba_pkg::CMD_RELEASE: wdata_d = rdata & ~(32'd1 << bitsel);
          fba_pkg::CMD_TEST: isu_d = rdata[bitsel];
          fba_pkg::CMD_ALLOC: begin
            if (has_zero) begin
              wdata_d = rdata | (32'd1 << ffz);
              idx_d   = 15'({addr_q[AW-1:0], ffz});
              st_d    = fba_pkg::ST_OK;
              addr_d  = addr_q;
            end
          end
          fba_pkg::CMD_RUN: begin
            run_d = run_end;
            if (run_hit) begin
              idx_d = 15'(fbase + (CW+5)'(run_bit) + 1'b1 - (CW+5)'(want_q));
              st_d  = fba_pkg::ST_OK;
            end
          end
          fba_pkg::CMD_USAGE: begin
            used_d = used_q + CW'(pop);
            if ((32'(used_q) + 32'(pop)) > 32'(fba_pkg::KibMax / 4)) begin
              kib_d = 18'(fba_pkg::KibMax);
            end else begin
              kib_d = 18'((32'(used_q) + 32'(pop)) << 2);
            end
          end
          default: ;
        endcase
      end
      fba_pkg::S_WRITE: begin
        we    = 1'b1;
        waddr = (cmd_q == fba_pkg::CMD_ALLOC) ? addr_q[AW-1:0] : fword;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fba_pkg::S_CLEAR;
      fcount_q <= 16'd32768;
      addr_q   <= '0;
      outv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      if (cfg_we_i) fcount_q <= cfg_wdata_i;
      if (state_q == fba_pkg::S_DONE) outv_q <= 1'b1;
      else if (outv_q && !out_stall_i) outv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= command_i;
      frame_q <= frame_address_i[31:fba_pkg::FrameShift];
      want_q  <= run_length_i;
    end
    run_q   <= run_d;
    used_q  <= used_d;
    idx_q   <= idx_d;
    isu_q   <= isu_d;
    kib_q   <= kib_d;
    st_q    <= st_d;
    wdata_q <= wdata_d;
  end

  assign out_valid_o   = outv_q;
  assign frame_index_o = idx_q;
  assign is_used_o     = isu_q;
  assign used_kib_o    = kib_q;
  assign status_o      = st_q;

endmodule
`default_nettype wire

/* rtl/fba_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module fba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* dv/tb_frame_bitmap_allocator_unit.sv */
`timescale 1ns / 1ps
module tb_frame_bitmap_allocator_unit;
  import fba_pkg::*;

  localparam int unsigned MaxFrames  = 32768;
  localparam int unsigned MapWords   = MaxFrames / WordBits;
  localparam int unsigned CycleLimit = 4000000;
  localparam logic [2:0]  CmdSpare6  = 3'd6;
  localparam logic [2:0]  CmdSpare7  = 3'd7;

  typedef struct packed {
    logic [14:0] frame_index;
    logic        is_used;
    logic [17:0] used_kib;
    logic [1:0]  status;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  command_i = '0;
  logic [31:0] frame_address_i = '0;
  logic [15:0] run_length_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [14:0] frame_index_o;
  logic        is_used_o;
  logic [17:0] used_kib_o;
  logic [1:0]  status_o;

  // Shadow copy of the block state, advanced once per accepted request.
  logic [31:0] shadow_map [MapWords];
  logic [15:0] shadow_count;
  answer_t     pending_answers[$];

  int unsigned errors = 0;
  int unsigned answers_seen = 0;
  int unsigned full_seen = 0;
  int unsigned range_seen = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  always #2 clk_i = ~clk_i;

  frame_bitmap_allocator_unit #(.MAX_FRAMES(MaxFrames)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .command_i, .frame_address_i, .run_length_i, .out_valid_o, .out_stall_i,
    .frame_index_o, .is_used_o, .used_kib_o, .status_o
  );

  // Computes the answer to one request and applies its side effects to the
  // shadow bitmap.
  task automatic allocator_answer(input logic [2:0] cmd, input logic [31:0] addr,
                                  input logic [15:0] want, output answer_t ans);
    int unsigned frame;
    int unsigned limit;
    int unsigned run;
    int unsigned n;
    bit found;
    frame = addr >> FrameShift;
    limit = (shadow_count > MaxFrames) ? MaxFrames : shadow_count;
    ans = '0;
    found = 1'b0;
    case (cmd)
      CMD_MARK: begin
        if (frame < limit) shadow_map[frame / 32][frame % 32] = 1'b1;
        else ans.status = ST_RANGE;
      end
      CMD_RELEASE: begin
        if (frame < MaxFrames) shadow_map[frame / 32][frame % 32] = 1'b0;
        else ans.status = ST_RANGE;
      end
      CMD_TEST: begin
        if (frame < MaxFrames) ans.is_used = shadow_map[frame / 32][frame % 32];
        else ans.status = ST_RANGE;
      end
      CMD_ALLOC: begin
        ans.status = ST_FULL;
        // Only whole words below the count take part.
        for (int w = 0; w < limit / 32 && !found; w++) begin
          for (int b = 0; b < 32 && !found; b++) begin
            if (!shadow_map[w][b]) begin
              shadow_map[w][b] = 1'b1;
              ans.frame_index = 15'(w * 32 + b);
              ans.status = ST_OK;
              found = 1'b1;
            end
          end
        end
      end
      CMD_RUN: begin
        ans.status = ST_FULL;
        if (want == 0) begin
          if (limit > 0) ans.status = ST_OK;
        end else begin
          run = 0;
          for (int unsigned f = 0; f < limit && !found; f++) begin
            if (shadow_map[f / 32][f % 32]) run = 0;
            else begin
              run++;
              if (run >= want) begin
                ans.frame_index = 15'(f + 1 - want);
                ans.status = ST_OK;
                found = 1'b1;
              end
            end
          end
        end
      end
      CMD_USAGE: begin
        n = 0;
        for (int w = 0; w < limit / 32; w++) n += $countones(shadow_map[w]);
        ans.used_kib = (n > KibMax / 4) ? 18'(KibMax) : 18'(n * 4);
      end
      default: ;
    endcase
  endtask

  // Offers one request, with a random gap in front unless quiet, and records
  // the expected answer at the edge where it is taken.
  task automatic send_request(input logic [2:0] cmd, input logic [31:0] addr,
                              input logic [15:0] want);
    answer_t ans;
    if (!quiet) begin
      while ($urandom_range(0, 99) < 26) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    frame_address_i <= addr;
    run_length_i    <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    allocator_answer(cmd, addr, want, ans);
    pending_answers.push_back(ans);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Drains all outstanding answers first, so the block is idle when the count is written.
  task automatic write_frame_count(input logic [15:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_count = value;
  endtask

  function automatic logic [31:0] pick_address();
    int unsigned span;
    if ($urandom_range(0, 99) < 15) return $urandom();
    span = ((shadow_count > MaxFrames) ? MaxFrames : shadow_count) + 40;
    return ($urandom_range(0, span - 1) << FrameShift) | $urandom_range(0, 4095);
  endfunction

  function automatic logic [15:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'($urandom());
    if (r < 20) return 16'd0;
    return 16'($urandom_range(1, 40));
  endfunction

  task automatic random_request;
    int unsigned r;
    logic [2:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 30) cmd = CMD_MARK;
    else if (r < 45) cmd = CMD_RELEASE;
    else if (r < 60) cmd = CMD_TEST;
    else if (r < 75) cmd = CMD_ALLOC;
    else if (r < 88) cmd = CMD_RUN;
    else if (r < 95) cmd = CMD_USAGE;
    else cmd = $urandom_range(0, 1) ? CmdSpare6 : CmdSpare7;
    send_request(cmd, pick_address(), pick_length());
  endtask

  // Edge cases of the address and length fields at the reset frame count,
  // plus both spare command codes.
  task automatic test_directed_full_map;
    send_request(CMD_TEST, 32'h0, 16'd0);
    send_request(CMD_MARK, 32'h0000_0FFF, 16'hFFFF);
    send_request(CMD_MARK, 32'h07FF_F000, 16'd0);
    send_request(CMD_TEST, 32'h07FF_FABC, 16'd0);
    send_request(CMD_MARK, 32'h7FFF_FFFF, 16'd0);
    send_request(CMD_RELEASE, 32'hFFFF_FFFF, 16'd0);
    send_request(CMD_TEST, 32'hFFFF_FFFF, 16'd0);
    send_request(CMD_ALLOC, 32'h0, 16'd0);
    send_request(CMD_RUN, 32'h0, 16'd0);
    send_request(CMD_RUN, 32'h0, 16'd32768);
    send_request(CMD_RUN, 32'h0, 16'd3);
    send_request(CMD_USAGE, 32'h0, 16'd0);
    send_request(CmdSpare6, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(CmdSpare7, 32'h0, 16'd0);
    send_request(CMD_RELEASE, 32'h07FF_F000, 16'd0);
  endtask

  // A zero frame count leaves nothing to allocate or search, and marks fail.
  task automatic test_directed_empty_map;
    write_frame_count(16'd0);
    send_request(CMD_ALLOC, 32'h0, 16'd0);
    send_request(CMD_RUN, 32'h0, 16'd0);
    send_request(CMD_MARK, 32'h0, 16'd0);
    send_request(CMD_USAGE, 32'h0, 16'd0);
    send_request(CMD_RELEASE, 32'h0, 16'd0);
  endtask

  // Counts above the store size saturate; a partial last word is skipped by
  // allocate and usage but seen by the run search.
  task automatic test_directed_odd_counts;
    write_frame_count(16'hFFFF);
    send_request(CMD_MARK, 32'h07FF_F000, 16'd0);
    send_request(CMD_USAGE, 32'h0, 16'd0);
    write_frame_count(16'd33);
    send_request(CMD_RUN, 32'h0, 16'd31);
    send_request(CMD_USAGE, 32'h0, 16'd0);
  endtask

  task automatic test_random_phase(input logic [15:0] count, input int unsigned items);
    write_frame_count(count);
    repeat (items) random_request();
  endtask

  // The receiver holds off long enough that the output register is full and
  // the input stalls, then the sender waits until all answers are in and sends a second batch.
  task automatic test_back_pressure;
    write_frame_count(16'd128);
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    repeat (20) random_request();
    drain();
    repeat (20) random_request();
  endtask

  task automatic test_no_idle_stretch;
    quiet = 1'b1;
    test_random_phase(16'd256, 60);
    quiet = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left   <= 300;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 26);
    end
  end

  always @(posedge clk_i) begin
    answer_t want_ans;
    if (out_valid_o && !out_stall_i) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected answer idx=%0d used=%0d kib=%0d status=%0d", $time,
                 frame_index_o, is_used_o, used_kib_o, status_o);
      end else begin
        want_ans = pending_answers.pop_front();
        if (want_ans.status == ST_FULL) full_seen++;
        if (want_ans.status == ST_RANGE) range_seen++;
        if (frame_index_o !== want_ans.frame_index) begin
          errors++;
          $display("%0t: frame_index expected %0d actual %0d", $time,
                   want_ans.frame_index, frame_index_o);
        end
        if (is_used_o !== want_ans.is_used) begin
          errors++;
          $display("%0t: is_used expected %0d actual %0d", $time,
                   want_ans.is_used, is_used_o);
        end
        if (used_kib_o !== want_ans.used_kib) begin
          errors++;
          $display("%0t: used_kib expected %0d actual %0d", $time,
                   want_ans.used_kib, used_kib_o);
        end
        if (status_o !== want_ans.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time,
                   want_ans.status, status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout with %0d answers outstanding", $time, pending_answers.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int w = 0; w < MapWords; w++) shadow_map[w] = '0;
    shadow_count = 16'd32768;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_full_map();
    test_directed_empty_map();
    test_directed_odd_counts();
    test_random_phase(16'd64, 90);
    test_random_phase(16'($urandom_range(1, 1500)), 100);
    test_back_pressure();
    test_no_idle_stretch();
    test_random_phase(16'd31, 40);
    test_random_phase(16'($urandom()), 60);
    test_random_phase(16'hFFFF, 30);
    test_random_phase(16'($urandom_range(32, 700)), 140);
    drain();
    repeat (50) @(posedge clk_i);
    if (pending_answers.size() != 0) errors++;
    $display("Run covered %0d answers over frame counts from 0 to 65535,", answers_seen);
    $display("with %0d exhausted and %0d out-of-range outcomes.", full_seen, range_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
